### design/zbsf_pkg.sv
`timescale 1ns / 1ps
package zbsf_pkg;
    localparam int FB_WIDTH   = 256;
    localparam int FB_HEIGHT  = 256;
    localparam int FB_SIZE    = FB_WIDTH * FB_HEIGHT;
    localparam int FB_AW      = $clog2(FB_SIZE);
    localparam int TEX_LOG    = 6;
    localparam int TEX_AW     = 2 * TEX_LOG;
    localparam int PIXEL_BITS = 32;

    typedef enum logic [2:0] {
        OP_CLEAR    = 3'd0,
        OP_TEXEL    = 3'd1,
        OP_FLAT     = 3'd2,
        OP_TEXTURED = 3'd3,
        OP_READ     = 3'd4
    } t_op;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_MUL, S_RUN, S_READ, S_RDWAIT, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic step;
        logic clr;
        logic tex_wr;
        logic rd;
        logic capture;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic last;
    } t_stat;
endpackage

### design/zbsf_ctrl.sv
`timescale 1ns / 1ps
module zbsf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2:0]      i_op,
    input  zbsf_pkg::t_stat i_stat,
    input  logic            i_out_ready,
    output logic            o_ready,
    output logic            o_out_valid,
    output zbsf_pkg::t_cmd  o_cmd
);
    import zbsf_pkg::*;
    t_state r_state, n_state;
    t_op    r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_CLEAR;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_op = t_op'(i_op);
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                case (r_op)
                    OP_TEXEL: begin
                        o_cmd.tex_wr = 1'b1;
                        n_state = S_OUT;
                    end
                    OP_CLEAR: n_state = S_RUN;
                    OP_FLAT, OP_TEXTURED: n_state = i_stat.bad ? S_OUT : S_MUL;
                    OP_READ: n_state = i_stat.bad ? S_OUT : S_READ;
                    default: n_state = S_OUT;
                endcase
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_RUN;
            end
            S_RUN: begin
                if (r_op == OP_CLEAR) o_cmd.clr = 1'b1;
                else o_cmd.step = 1'b1;
                if (i_stat.last) n_state = S_OUT;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state = S_RDWAIT;
            end
            S_RDWAIT: begin
                o_cmd.capture = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_ready) else $error("valid and ready together");
    a_mul_then_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_RUN)) else $error("mul not followed by run");
    a_load_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_SETUP)) else $error("load without setup");
endmodule

### design/zbsf_datapath.sv
`timescale 1ns / 1ps
module zbsf_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  zbsf_pkg::t_cmd   i_cmd,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [8:0]       i_cfg_data,
    input  logic [2:0]       i_op,
    input  logic [7:0]       i_row,
    input  logic [7:0]       i_xl,
    input  logic [7:0]       i_xr,
    input  logic [15:0]      i_zl,
    input  logic [15:0]      i_zr,
    input  logic [15:0]      i_ul,
    input  logic [15:0]      i_ur,
    input  logic [15:0]      i_vl,
    input  logic [15:0]      i_vr,
    input  logic [31:0]      i_color,
    input  logic [11:0]      i_tidx,
    output zbsf_pkg::t_stat  o_stat,
    output logic [31:0]      o_pixel_color,
    output logic [15:0]      o_pixel_depth,
    output logic             o_status
);
    import zbsf_pkg::*;

    logic [PIXEL_BITS-1:0] r_cbuf [FB_SIZE];
    logic [15:0]           r_zbuf [FB_SIZE];
    logic [PIXEL_BITS-1:0] r_tex  [2**TEX_AW];

    logic [8:0]  r_aw, r_ah;
    logic [2:0]  r_op;
    logic [7:0]  r_row, r_xl, r_xr;
    logic [15:0] r_zl, r_zr, r_ul, r_ur, r_vl, r_vr;
    logic [31:0] r_color;
    logic [11:0] r_tidx;
    logic [15:0] r_dz, r_du, r_dv, r_z, r_u, r_v;
    logic [16:0] r_recip;
    logic [8:0]  r_cnt;
    logic [16:0] r_pos;
    logic        r_bad;
    logic [16:0] r_clr_end;
    // write-back pipe stage
    logic        r_wb_v, r_wb_tex;
    logic [FB_AW-1:0] r_wb_pos;
    logic [15:0] r_wb_z;
    logic [15:0] r_wb_old;
    logic [PIXEL_BITS-1:0] r_wb_texel;
    logic [PIXEL_BITS-1:0] r_rd_c;
    logic [15:0] r_rd_z;
    logic [31:0] r_out_c;
    logic [15:0] r_out_z;

    logic [8:0]  n_cfg;
    logic        bad;
    logic [16:0] base;
    logic [TEX_AW-1:0] taddr;
    logic [16:0] recip_tab [256];

    // Q15 reciprocal table, entry 0 is 1
    assign recip_tab[0] = 17'd1;
    for (genvar g = 1; g < 256; g++) begin : g_recip
        localparam logic [16:0] RECIP_VAL = 17'(32768 / g);
        assign recip_tab[g] = RECIP_VAL;
    end

    function automatic logic [15:0] stepf(input logic [15:0] l, input logic [15:0] r,
                                          input logic [16:0] rc);
        logic signed [15:0] d;
        logic signed [33:0] p;
        d = signed'(r - l);
        p = 34'(d) * signed'({1'b0, rc});
        return p[30:15];
    endfunction

    always_comb begin
        n_cfg = (i_cfg_data == 9'd0) ? 9'd1 : i_cfg_data;
        if (i_cfg_idx == CFG_WIDTH) begin
            if (i_cfg_data > 9'(FB_WIDTH)) n_cfg = 9'(FB_WIDTH);
        end else begin
            if (i_cfg_data > 9'(FB_HEIGHT)) n_cfg = 9'(FB_HEIGHT);
        end
        bad = 1'b0;
        case (r_op)
            OP_FLAT, OP_TEXTURED:
                bad = (r_xl > r_xr) || ({1'b0, r_row} >= r_ah) || ({1'b0, r_xr} >= r_aw);
            OP_READ: bad = ({1'b0, r_row} >= r_ah) || ({1'b0, r_xl} >= r_aw);
            OP_CLEAR, OP_TEXEL: bad = 1'b0;
            default: bad = 1'b1;
        endcase
        base = 17'(r_row * r_aw) + {9'd0, r_xl};
        taddr = {r_v[TEX_AW-1:TEX_LOG], r_u[TEX_AW-1:TEX_LOG]};
        o_stat.bad = bad;
        o_stat.last = (r_op == OP_CLEAR) ? (r_pos + 17'd1 >= r_clr_end)
                                         : (r_cnt == {1'b0, r_xr - r_xl});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aw   <= 9'd256;
            r_ah   <= 9'd256;
            r_wb_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WIDTH) r_aw <= n_cfg;
                else r_ah <= n_cfg;
            end
            r_wb_v <= i_cmd.step && (r_pos < 17'(FB_SIZE));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op; r_row <= i_row; r_xl <= i_xl; r_xr <= i_xr;
            r_zl <= i_zl; r_zr <= i_zr; r_ul <= i_ul; r_ur <= i_ur;
            r_vl <= i_vl; r_vr <= i_vr; r_color <= i_color; r_tidx <= i_tidx;
        end
        if (i_cmd.setup) begin
            r_bad   <= bad;
            r_recip <= recip_tab[r_xr - r_xl];
            r_pos   <= (r_op == OP_CLEAR) ? 17'd0 : base;
            r_clr_end <= 17'(r_aw * r_ah);
            r_cnt   <= 9'd0;
            r_z <= r_zl; r_u <= r_ul; r_v <= r_vl;
            r_out_c <= 32'd0;
            r_out_z <= 16'd0;
        end
        if (i_cmd.tex_wr) r_tex[r_tidx[TEX_AW-1:0]] <= r_color[PIXEL_BITS-1:0];
        if (i_cmd.mul) begin
            r_dz <= stepf(r_zl, r_zr, r_recip);
            r_du <= stepf(r_ul, r_ur, r_recip);
            r_dv <= stepf(r_vl, r_vr, r_recip);
        end
        if (i_cmd.clr) begin
            r_cbuf[r_pos[FB_AW-1:0]] <= '0;
            r_zbuf[r_pos[FB_AW-1:0]] <= '0;
            r_pos <= r_pos + 17'd1;
        end
        if (i_cmd.step) begin
            r_wb_pos   <= r_pos[FB_AW-1:0];
            r_wb_z     <= r_z;
            r_wb_tex   <= (r_op == OP_TEXTURED);
            r_wb_texel <= r_tex[taddr];
            r_wb_old   <= r_zbuf[r_pos[FB_AW-1:0]];
            r_z <= r_z + r_dz; r_u <= r_u + r_du; r_v <= r_v + r_dv;
            r_pos <= r_pos + 17'd1;
            r_cnt <= r_cnt + 9'd1;
        end
        if (r_wb_v && (signed'(r_wb_old) < signed'(r_wb_z))) begin
            r_zbuf[r_wb_pos] <= r_wb_z;
            r_cbuf[r_wb_pos] <= r_wb_tex ? r_wb_texel : r_color[PIXEL_BITS-1:0];
        end
        if (i_cmd.rd) begin
            r_rd_c <= r_cbuf[r_pos[FB_AW-1:0]];
            r_rd_z <= r_zbuf[r_pos[FB_AW-1:0]];
        end
        if (i_cmd.capture) begin
            r_out_c <= 32'(r_rd_c);
            r_out_z <= r_rd_z;
        end
    end

    assign o_pixel_color = r_out_c;
    assign o_pixel_depth = r_out_z;
    assign o_status      = r_bad;

    a_cfg_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_aw != 9'd0) && (r_ah != 9'd0)) else $error("zero active size");
    a_step_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_cnt == $past(r_cnt) + 9'd1)) else $error("count slip");
    a_no_clr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clr && i_cmd.step)) else $error("clear and step together");
endmodule

### design/zbuffer_span_filler.sv
`timescale 1ns / 1ps
// Throughput: one word at a time; the pixel loop writes one pixel per cycle through
// a one-stage depth read and write-back.
// Reset: synchronous, active low; active size returns to 256 by 256. Buffers hold
// unknown data until the first clear.
module zbuffer_span_filler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[2:0] row[10:3] x_left[18:11] x_right[26:19] z_left z_right u_left u_right
    // v_left v_right color_value[154:123] texel_index[166:155]
    input  logic [167:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_color[31:0] pixel_depth[47:32]
    output logic [47:0] m_axis_tdata,
    // status
    output logic        m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [8:0]  i_cfg_data
);
    import zbsf_pkg::*;
    t_cmd  cmd;
    t_stat stat;
    logic [31:0] pc;
    logic [15:0] pd;

    zbsf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .i_op(s_axis_tdata[2:0]), .i_stat(stat), .i_out_ready(m_axis_tready),
        .o_ready(s_axis_tready), .o_out_valid(m_axis_tvalid), .o_cmd(cmd)
    );

    zbsf_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_op(s_axis_tdata[2:0]), .i_row(s_axis_tdata[10:3]),
        .i_xl(s_axis_tdata[18:11]), .i_xr(s_axis_tdata[26:19]),
        .i_zl(s_axis_tdata[42:27]), .i_zr(s_axis_tdata[58:43]),
        .i_ul(s_axis_tdata[74:59]), .i_ur(s_axis_tdata[90:75]),
        .i_vl(s_axis_tdata[106:91]), .i_vr(s_axis_tdata[122:107]),
        .i_color(s_axis_tdata[154:123]), .i_tidx(s_axis_tdata[166:155]),
        .o_stat(stat), .o_pixel_color(pc), .o_pixel_depth(pd), .o_status(m_axis_tuser)
    );

    assign m_axis_tdata = {pd, pc};
endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import zbsf_pkg::*;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  row;
        logic [7:0]  x_left;
        logic [7:0]  x_right;
        logic [15:0] z_left;
        logic [15:0] z_right;
        logic [15:0] u_left;
        logic [15:0] u_right;
        logic [15:0] v_left;
        logic [15:0] v_right;
        logic [31:0] color;
        logic [11:0] texel;
    } t_span_word;

    typedef struct packed {
        logic [31:0] color;
        logic [15:0] depth;
        logic        status;
    } t_pixel_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_idx = 1'b0;
    logic [8:0]   i_cfg_data = '0;

    zbuffer_span_filler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [31:0] color_mem [FB_SIZE];
    logic [15:0] depth_mem [FB_SIZE];
    logic [31:0] texel_mem [1 << TEX_AW];
    int act_w = 256;
    int act_h = 256;

    t_pixel_result pending_pixels[$];
    int src_idle = 0;
    int sink_idle = 0;
    bit sink_hold = 1'b0;
    int fails = 0;
    int words_sent = 0;
    int words_checked = 0;
    int spans_drawn = 0;

    function automatic int clamp_size(input logic [8:0] val);
        int x;
        x = int'(val);
        if (x < 1) x = 1;
        if (x > 256) x = 256;
        return x;
    endfunction

    function automatic int step_scale(input int len);
        if (len == 0) return 1;
        return 32768 / len;
    endfunction

    function automatic logic [15:0] span_slope(input logic [15:0] lft, input logic [15:0] rgt,
                                               input int len);
        logic [15:0] d;
        int p;
        d = rgt - lft;
        p = int'($signed(d)) * step_scale(len & 255);
        return 16'(p >>> 15);
    endfunction

    task automatic predict_pixel_op(input t_span_word w, output t_pixel_result r);
        int len;
        int pos;
        logic [15:0] z, u, v, dz, du, dv;
        logic [11:0] a;
        r = '0;
        case (w.op)
            OP_CLEAR: begin
                for (int i = 0; i < act_w * act_h; i++) begin
                    color_mem[i] = '0;
                    depth_mem[i] = '0;
                end
            end
            OP_TEXEL: texel_mem[w.texel] = w.color;
            OP_FLAT, OP_TEXTURED: begin
                if (w.x_left > w.x_right || w.row >= act_h || w.x_right >= act_w) begin
                    r.status = 1'b1;
                end else begin
                    spans_drawn++;
                    len = int'(w.x_right) - int'(w.x_left);
                    z = w.z_left;
                    u = w.u_left;
                    v = w.v_left;
                    dz = span_slope(w.z_left, w.z_right, len);
                    du = span_slope(w.u_left, w.u_right, len);
                    dv = span_slope(w.v_left, w.v_right, len);
                    pos = int'(w.row) * act_w + int'(w.x_left);
                    for (int i = 0; i <= len; i++) begin
                        if ($signed(depth_mem[pos]) < $signed(z)) begin
                            depth_mem[pos] = z;
                            if (w.op == OP_TEXTURED) begin
                                a = (u[11:0] >> TEX_LOG) | (v[11:0] & 12'hFC0);
                                color_mem[pos] = texel_mem[a];
                            end else begin
                                color_mem[pos] = w.color;
                            end
                        end
                        z = z + dz;
                        u = u + du;
                        v = v + dv;
                        pos++;
                    end
                end
            end
            OP_READ: begin
                if (w.row >= act_h || w.x_left >= act_w) begin
                    r.status = 1'b1;
                end else begin
                    pos = int'(w.row) * act_w + int'(w.x_left);
                    r.color = color_mem[pos];
                    r.depth = depth_mem[pos];
                end
            end
            default: r.status = 1'b1;
        endcase
    endtask

    task automatic send_word(input t_span_word w);
        t_pixel_result r;
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {1'b0, w.texel, w.color, w.v_right, w.v_left, w.u_right, w.u_left,
                        w.z_right, w.z_left, w.x_right, w.x_left, w.row, w.op};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pixel_op(w, r);
        pending_pixels.push_back(r);
        words_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    always @(negedge i_clk)
        m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle);

    always @(posedge i_clk) begin
        t_pixel_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected word: color %h depth %h status %b",
                       m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tuser);
                fails++;
            end else begin
                e = pending_pixels.pop_front();
                words_checked++;
                if (m_axis_tdata[31:0] !== e.color) begin
                    $error("pixel_color expected %h got %h", e.color, m_axis_tdata[31:0]);
                    fails++;
                end
                if (m_axis_tdata[47:32] !== e.depth) begin
                    $error("pixel_depth expected %h got %h", e.depth, m_axis_tdata[47:32]);
                    fails++;
                end
                if (m_axis_tuser !== e.status) begin
                    $error("status expected %b got %b", e.status, m_axis_tuser);
                    fails++;
                end
            end
        end
    end

    task automatic drain;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [8:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_WIDTH) act_w = clamp_size(val);
        else act_h = clamp_size(val);
    endtask

    function automatic t_span_word blank_word(input logic [2:0] op);
        t_span_word w;
        w = '0;
        w.op = op;
        return w;
    endfunction

    function automatic t_span_word random_word(input bit allow_clear);
        t_span_word w;
        int sel;
        int len;
        w = 167'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        sel = $urandom_range(99);
        if (sel < 45) begin
            w.op = ($urandom_range(1)) ? OP_FLAT : OP_TEXTURED;
            w.row = 8'($urandom_range(act_h - 1));
            len = ($urandom_range(9) == 0) ? $urandom_range(act_w - 1)
                                           : $urandom_range((act_w > 16 ? 16 : act_w) - 1);
            w.x_left = 8'($urandom_range(act_w - 1 - len));
            w.x_right = 8'(int'(w.x_left) + len);
        end else if (sel < 70) begin
            w.op = OP_READ;
            w.row = 8'($urandom_range(act_h - 1));
            w.x_left = 8'($urandom_range(act_w - 1));
        end else if (sel < 75) begin
            w.op = OP_READ;
        end else if (sel < 85) begin
            w.op = OP_TEXEL;
        end else if (sel < 93) begin
            w.op = ($urandom_range(1)) ? OP_FLAT : OP_TEXTURED;
        end else if (sel < 96) begin
            w.op = 3'(OP_READ) + 3'($urandom_range(1, 3));
        end else begin
            w.op = (allow_clear && act_w * act_h <= 4096) ? OP_CLEAR : OP_READ;
        end
        return w;
    endfunction

    task automatic test_directed;
        t_span_word w;
        send_word(blank_word(OP_CLEAR));
        for (int i = 0; i < (1 << TEX_AW); i++) begin
            w = blank_word(OP_TEXEL);
            w.texel = 12'(i);
            w.color = (i == 0) ? 32'hFFFF_FFFF : {$urandom};
            send_word(w);
        end
        w = blank_word(OP_FLAT);
        w.x_right = 8'd255;
        w.row = 8'd255;
        w.z_left = 16'h7FFF;
        w.z_right = 16'h8000;
        w.color = 32'hFFFF_FFFF;
        send_word(w);
        w = blank_word(OP_READ);
        w.row = 8'd255;
        send_word(w);
        w.x_left = 8'd255;
        send_word(w);
        w = blank_word(OP_FLAT);
        w.row = 8'd3;
        w.x_left = 8'd7;
        w.x_right = 8'd7;
        w.z_left = 16'd5;
        w.z_right = 16'h8000;
        w.color = 32'h1234_5678;
        send_word(w);
        w.z_left = 16'd5;
        w.color = 32'hDEAD_BEEF;
        send_word(w);
        w.z_left = 16'd6;
        send_word(w);
        w = blank_word(OP_TEXTURED);
        w.row = 8'd10;
        w.x_left = 8'd0;
        w.x_right = 8'd1;
        w.z_left = 16'd100;
        w.z_right = 16'd100;
        w.u_left = 16'h8000;
        w.u_right = 16'h7FFF;
        w.v_left = 16'hFFFF;
        w.v_right = 16'h0000;
        send_word(w);
        w.x_left = 8'd0;
        w.x_right = 8'd255;
        w.z_left = 16'd200;
        w.z_right = 16'hFFFF;
        send_word(w);
        w = blank_word(OP_FLAT);
        w.x_left = 8'd9;
        w.x_right = 8'd8;
        w.z_left = 16'd1;
        send_word(w);
        for (int k = 1; k <= 3; k++) send_word(blank_word(3'(OP_READ) + 3'(k)));
        w = blank_word(OP_TEXEL);
        w.texel = 12'hFFF;
        w.color = 32'h0;
        send_word(w);
        w = blank_word(OP_READ);
        w.row = 8'd10;
        send_word(w);
        w.x_left = 8'd7;
        w.row = 8'd3;
        send_word(w);
        drain();
    endtask

    task automatic test_random(input int n, input int src_pct, input int sink_pct);
        src_idle = src_pct;
        sink_idle = sink_pct;
        for (int i = 0; i < n; i++) send_word(random_word(1'b1));
        drain();
        src_idle = 0;
        sink_idle = 0;
    endtask

    task automatic test_resize(input logic [8:0] wv, input logic [8:0] hv);
        write_cfg(CFG_WIDTH, wv);
        write_cfg(CFG_HEIGHT, hv);
        send_word(blank_word(OP_CLEAR));
        drain();
    endtask

    task automatic test_output_stall;
        sink_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                sink_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < 60; i++) send_word(random_word(1'b0));
        drain();
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(600, 12, 82);
        test_resize(9'd40, 9'd20);
        test_random(600, 82, 12);
        test_resize(9'd0, 9'd511);
        test_random(300, 0, 0);
        test_resize(9'd256, 9'd1);
        test_output_stall();
        test_random(300, 0, 0);
        test_resize(9'd17, 9'd33);
        test_random(200, 0, 0);
        $display("Sent %0d words (%0d spans drawn), checked %0d results,", words_sent,
                 spans_drawn, words_checked);
        $display("across five active sizes incl. 1x256 and 256x1, with stalls on both sides.");
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule
